// ===== rtl/core/lifo_stack_with_search_defines.svh =====
// Assertion macros for the LIFO stack with search.
// Used by the top level; relies on signals named clk and rst in scope.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lss_pkg.sv =====
// Shared types for the LIFO stack with search.
// No dependencies; imported by the front, back and top level.
package lss_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  // Request item as seen on the input port
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  // Result item as seen on the output port
  typedef struct packed {
    logic               ok;
    logic signed [31:0] data;
    logic               found;
    logic [6:0]         fill_count;
    logic               is_empty;
  } rsp_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

endpackage

// ===== rtl/core/lss_front.sv =====
// Front end: accepts request items, decodes the operation and queues them.
// Depends on lss_pkg.
module lss_front
  import lss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  // two-entry command queue
  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;
  logic       push_q;
  logic       pop_q;
  cmd_t       cmd_in;

  // decode the request into a command
  always_comb begin
    cmd_in.op    = op_t'(req.func);
    cmd_in.value = req.value;
  end

  assign req_ready = (level != 2'd2);
  assign push_q    = req_valid && req_ready;
  assign cmd_valid = (level != 2'd0);
  assign pop_q     = cmd_valid && cmd_ready;
  assign cmd       = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push_q) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push_q) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_q) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_q, pop_q})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== rtl/core/lss_back.sv =====
// Back end: stack memory, entry count, search scan and the result register.
// Depends on lss_pkg.
module lss_back
  import lss_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp,
  output logic          busy,
  output logic [CW-1:0] count
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  bk_state_t          state;
  bk_state_t          state_next;
  logic [CW-1:0]      count_next;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      idx_next;
  logic signed [31:0] key;
  logic               found_r;
  logic               found_next;

  logic               out_free;
  logic               full;
  logic               empty;
  logic               hit;
  logic               last;
  logic               we;
  logic               re;
  logic [AW-1:0]      raddr;
  logic               ld;
  logic               ld_ok;
  logic signed [31:0] ld_data;
  logic               ld_found;
  logic               key_ld;

  assign out_free = !rsp_valid || rsp_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign hit      = (rd_data == key);
  assign last     = (idx == AW'(count - CW'(1)));
  assign busy     = (state != BK_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && !empty) begin
          if (cmd.op == OP_POP || cmd.op == OP_PEEK) begin
            state_next = BK_READ;
          end else if (cmd.op == OP_SEARCH) begin
            state_next = BK_SCAN;
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_SCAN: begin
        if (hit || last) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready  = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    raddr      = '0;
    ld         = 1'b0;
    ld_ok      = 1'b0;
    ld_data    = '0;
    ld_found   = 1'b0;
    key_ld     = 1'b0;
    count_next = count;
    idx_next   = idx;
    found_next = found_r;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_PUSH: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                ld        = 1'b1;
                if (!full) begin
                  we         = 1'b1;
                  ld_ok      = 1'b1;
                  count_next = count + CW'(1);
                end
              end
            end
            OP_POP, OP_PEEK: begin
              if (empty) begin
                if (out_free) begin
                  cmd_ready = 1'b1;
                  ld        = 1'b1;
                end
              end else begin
                cmd_ready = 1'b1;
                re        = 1'b1;
                raddr     = AW'(count - CW'(1));
                if (cmd.op == OP_POP) begin
                  count_next = count - CW'(1);
                end
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                if (out_free) begin
                  cmd_ready = 1'b1;
                  ld        = 1'b1;
                  ld_ok     = 1'b1;
                end
              end else begin
                cmd_ready = 1'b1;
                re        = 1'b1;
                key_ld    = 1'b1;
                idx_next  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_ok   = 1'b1;
          ld_data = rd_data;
        end
      end
      BK_SCAN: begin
        if (hit || last) begin
          found_next = hit;
        end else begin
          re       = 1'b1;
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end
      BK_DONE: begin
        if (out_free) begin
          ld       = 1'b1;
          ld_ok    = 1'b1;
          ld_found = found_r;
        end
      end
      default: ;
    endcase
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(count)] <= cmd.value;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  // sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (ld) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // scan and result payload
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    found_r <= found_next;
    if (key_ld) begin
      key <= cmd.value;
    end
    if (ld) begin
      rsp.ok         <= ld_ok;
      rsp.data       <= ld_data;
      rsp.found      <= ld_found;
      rsp.fill_count <= 7'(count_next);
      rsp.is_empty   <= (count_next == '0);
    end
  end

endmodule

// ===== rtl/core/lifo_stack_with_search.sv =====
// Back end steps: a push is taken and writes its result register; pop and peek issue a
// registered memory read, then load the result; search loads the key and the first read,
// compares one stored entry per cycle with early exit on a hit, then loads the result.
// One push per cycle while the result register is free; no command is taken while busy.
// Synchronous active-high reset empties the stack and command queue; memory is not cleared.
// Depends on lss_pkg, lss_front, lss_back and lifo_stack_with_search_defines.svh.
`include "lifo_stack_with_search_defines.svh"

module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          cmd_valid;
  logic          cmd_ready;
  cmd_t          cmd;
  logic          busy;
  logic [CW-1:0] count;

  // request decode and queue
  lss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // stack execution
  lss_back #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .busy      (busy),
    .count     (count)
  );

  // checks
  `LSS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "entry count beyond capacity")
  `LSS_ASSERT_NOW(a_busy_no_take, busy, !cmd_ready, "command taken while back end busy")
  `LSS_ASSERT_NEXT(a_push_grows,
    cmd_valid && cmd_ready && cmd.op == OP_PUSH && count != CW'(DEPTH),
    count == $past(count) + CW'(1), "push did not grow the stack")
  `LSS_ASSERT_NEXT(a_pop_shrinks,
    cmd_valid && cmd_ready && cmd.op == OP_POP && count != '0,
    count == $past(count) - CW'(1), "pop did not shrink the stack")

endmodule
